// ----- rtl/rmst_pkg.sv -----
// ----------------------------------------------------------------------------
// rmst_pkg
// shared types and constants of the range maximum segment tree core
// ----------------------------------------------------------------------------
package rmst_pkg;

	localparam int POS_W  = 10;
	localparam int VAL_W  = 64;
	localparam int SIZE_W = 11;

	// empty sentinel, also the identity of the signed maximum
	localparam logic [VAL_W-1:0] EMPTY_VALUE = {1'b1, {(VAL_W-1){1'b0}}};

	localparam logic [SIZE_W-1:0] ACTIVE_SIZE_RESET = 11'd1024;

	// register index of active_size (byte address bit 2)
	localparam logic REG_ACTIVE_SIZE = 1'b0;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef struct packed {
		logic             mode;
		logic [POS_W-1:0] position;
		logic [POS_W-1:0] range_low;
		logic [POS_W-1:0] range_high;
		logic [VAL_W-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic [VAL_W-1:0] max_value;
		logic             empty_range;
	} res_t;

endpackage

// ----- rtl/rmst_node_ram.sv -----
// ----------------------------------------------------------------------------
// rmst_node_ram
// node store: one write port, two registered read ports
// ----------------------------------------------------------------------------
module rmst_node_ram import rmst_pkg::*; #(
	parameter int DEPTH = 2048,
	parameter int AW    = 11
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [VAL_W-1:0] wdata,
	input  logic [AW-1:0]    ra,
	input  logic [AW-1:0]    rb,
	output logic [VAL_W-1:0] rd_a,
	output logic [VAL_W-1:0] rd_b
);

	logic [VAL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_a <= mem[ra];
		rd_b <= mem[rb];
	end

endmodule

// ----- rtl/rmst_apb_regs.sv -----
// ----------------------------------------------------------------------------
// rmst_apb_regs
// configuration register file behind the apb port
// ----------------------------------------------------------------------------
module rmst_apb_regs import rmst_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output logic [SIZE_W-1:0] active_size
);

	logic [SIZE_W-1:0] active_size_q;
	logic              wr_en;

	assign pready      = 1'b1;
	assign wr_en       = psel && penable && pwrite && pready;
	assign active_size = active_size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_size_q <= ACTIVE_SIZE_RESET;
		end else if (wr_en && (paddr[2] == REG_ACTIVE_SIZE)) begin
			active_size_q <= pwdata[SIZE_W-1:0];
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_ACTIVE_SIZE: prdata = {{(32-SIZE_W){1'b0}}, active_size_q};
			default:         prdata = '0;
		endcase
	end

endmodule

// ----- rtl/rmst_engine.sv -----
// ----------------------------------------------------------------------------
// rmst_engine
// sequencer for clearing pass, leaf-to-root write walk and range queries
// ----------------------------------------------------------------------------
module rmst_engine import rmst_pkg::*; #(
	parameter int LEAF_COUNT = 1024,
	parameter int AW         = 11,
	parameter int IW         = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_item_t          in_item,
	input  logic [SIZE_W-1:0] active_size,
	output logic              res_valid,
	input  logic              res_ready,
	output res_t              res,
	output logic              ram_we,
	output logic [AW-1:0]     ram_waddr,
	output logic [VAL_W-1:0]  ram_wdata,
	output logic [AW-1:0]     ram_ra,
	output logic [AW-1:0]     ram_rb,
	input  logic [VAL_W-1:0]  ram_rd_a,
	input  logic [VAL_W-1:0]  ram_rd_b
);

	localparam int NODE_COUNT = 2 * LEAF_COUNT;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_WALK  = 3'd2;
	localparam logic [2:0] ST_QUERY = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]       state_q;
	logic [AW-1:0]    clr_q;
	logic             v_s1;
	logic             take_l_s1;
	logic             take_r_s1;
	logic [AW-1:0]    node_q;
	logic [VAL_W-1:0] cur_q;
	logic [VAL_W-1:0] best_q;
	logic             empty_q;
	logic [IW-1:0]    ql_q;
	logic [IW-1:0]    qr_q;

	logic [31:0]      eff32;
	logic [31:0]      hi32;
	logic             pos_ok;
	logic             q_empty;
	logic [AW-1:0]    leaf;
	logic [IW-1:0]    left_init;
	logic [IW-1:0]    right_init;
	logic [IW-1:0]    qr_dec;
	logic [AW-1:0]    parent;
	logic [VAL_W-1:0] walk_max;
	logic [VAL_W-1:0] acc_a;
	logic [VAL_W-1:0] acc_b;
	logic             accept;

	// effective size and bounds
	always_comb begin
		eff32 = (32'(active_size) < 32'(LEAF_COUNT)) ? 32'(active_size) : 32'(LEAF_COUNT);
		pos_ok = 32'(in_item.position) < eff32;
		hi32 = (32'(in_item.range_high) > (eff32 - 32'd1)) ? (eff32 - 32'd1)
			: 32'(in_item.range_high);
		q_empty = (eff32 == 32'd0) || (32'(in_item.range_low) > hi32);
		leaf = AW'(32'(in_item.position) + 32'(LEAF_COUNT));
		left_init = IW'(32'(in_item.range_low) + 32'(LEAF_COUNT));
		right_init = IW'(hi32 + 32'(LEAF_COUNT) + 32'd1);
	end

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign qr_dec   = qr_q - IW'(1);
	assign parent   = {1'b0, node_q[AW-1:1]};
	assign walk_max = ($signed(ram_rd_a) > $signed(cur_q)) ? ram_rd_a : cur_q;

	// accumulator: left node first, then right node
	assign acc_a = (take_l_s1 && ($signed(ram_rd_a) > $signed(best_q))) ? ram_rd_a : best_q;
	assign acc_b = (take_r_s1 && ($signed(ram_rd_b) > $signed(acc_a))) ? ram_rd_b : acc_a;

	assign res_valid       = (state_q == ST_DONE);
	assign res.max_value   = best_q;
	assign res.empty_range = empty_q;

	// node store port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = leaf;
		ram_wdata = in_item.value;
		ram_ra    = ql_q[AW-1:0];
		ram_rb    = qr_dec[AW-1:0];
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = EMPTY_VALUE;
			end
			ST_IDLE: begin
				ram_we = in_valid && (in_item.mode == MODE_WRITE) && pos_ok;
				ram_ra = {leaf[AW-1:1], ~leaf[0]};
			end
			ST_WALK: begin
				ram_we    = 1'b1;
				ram_waddr = parent;
				ram_wdata = walk_max;
				ram_ra    = {parent[AW-1:1], ~parent[0]};
			end
			ST_QUERY, ST_DONE: begin
				ram_we = 1'b0;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			v_s1    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(NODE_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					v_s1 <= 1'b0;
					if (accept) begin
						if (in_item.mode == MODE_WRITE) begin
							if (pos_ok) begin
								state_q <= ST_WALK;
							end
						end else if (q_empty) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_QUERY;
						end
					end
				end
				ST_WALK: begin
					if (parent == AW'(1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_QUERY: begin
					if (ql_q < qr_q) begin
						v_s1 <= 1'b1;
					end else begin
						v_s1 <= 1'b0;
						if (!v_s1) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				node_q  <= leaf;
				cur_q   <= in_item.value;
				best_q  <= EMPTY_VALUE;
				empty_q <= q_empty;
				ql_q    <= left_init;
				qr_q    <= right_init;
			end
			ST_WALK: begin
				node_q <= parent;
				cur_q  <= walk_max;
			end
			ST_QUERY: begin
				if (v_s1) begin
					best_q <= acc_b;
				end
				if (ql_q < qr_q) begin
					take_l_s1 <= ql_q[0];
					take_r_s1 <= qr_q[0];
					ql_q      <= (ql_q + IW'(ql_q[0])) >> 1;
					qr_q      <= qr_q >> 1;
				end
			end
			default: begin
				cur_q <= cur_q;
			end
		endcase
	end

	a_query_read_only: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_QUERY || state_q == ST_DONE) |-> !ram_we)
		else $error("node store written during a query");

	a_walk_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (ram_waddr != ram_ra))
		else $error("walk reads the entry it writes");

	a_acc_in_query: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (state_q == ST_QUERY))
		else $error("accumulator stage active outside a query");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res)))
		else $error("pending result changed");

endmodule

// ----- rtl/range_max_segment_tree_core.sv -----
// write: the leaf is written on acceptance, then the leaf-to-root walk writes each ancestor
//   (log2 of LEAF_COUNT tree levels) through the single write port of the node store
// query: both bounds climb the tree level by level (up to log2 of 2*LEAF_COUNT levels), the
//   nodes at the bounds read through the two read ports; the last reads drain into the maximum
//   before the result is presented, and an empty range goes straight to the result
// one item at a time; a result waits in the output register while the next item is taken
// reset: all nodes cleared to the empty sentinel by a clearing pass, no item taken
// ----------------------------------------------------------------------------
// range_max_segment_tree_core
// range maximum table with point writes over a node store in synchronous memory
// ----------------------------------------------------------------------------
module range_max_segment_tree_core import rmst_pkg::*; #(
	parameter int LEAF_COUNT = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // position, range_low, range_high, value
	input  logic [0:0]  s_tuser,   // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // max_value
	output logic [0:0]  m_tuser,   // empty_range
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = $clog2(2 * LEAF_COUNT);
	localparam int IW = $clog2(2 * LEAF_COUNT + 1);

	in_item_t          in_item;
	res_t              res;
	res_t              out_q;
	logic              m_tvalid_q;
	logic              res_valid;
	logic              res_ready;
	logic [SIZE_W-1:0] active_size;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [VAL_W-1:0]  ram_wdata;
	logic [AW-1:0]     ram_ra;
	logic [AW-1:0]     ram_rb;
	logic [VAL_W-1:0]  ram_rd_a;
	logic [VAL_W-1:0]  ram_rd_b;

	assign in_item.mode       = s_tuser[0];
	assign in_item.position   = s_tdata[9:0];
	assign in_item.range_low  = s_tdata[19:10];
	assign in_item.range_high = s_tdata[29:20];
	assign in_item.value      = s_tdata[93:30];

	// output register
	assign res_ready = !m_tvalid_q || m_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = out_q.max_value;
	assign m_tuser   = out_q.empty_range;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	rmst_apb_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.active_size (active_size)
	);

	rmst_node_ram #(
		.DEPTH (2 * LEAF_COUNT),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.ra    (ram_ra),
		.rb    (ram_rb),
		.rd_a  (ram_rd_a),
		.rd_b  (ram_rd_b)
	);

	rmst_engine #(
		.LEAF_COUNT (LEAF_COUNT),
		.AW         (AW),
		.IW         (IW)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_item     (in_item),
		.active_size (active_size),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_ra      (ram_ra),
		.ram_rb      (ram_rb),
		.ram_rd_a    (ram_rd_a),
		.ram_rd_b    (ram_rd_b)
	);

endmodule
